// ----- rtl/eic_pkg.sv -----
// Shared types and constants for the equal-interval pixel classifier.
// Used by eic_div, eic_cell and equal_interval_pixel_classifier_unit.
`timescale 1ns / 1ps
`default_nettype none

package eic_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int IDX_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int DATA_W      = 32;
    localparam int BND_W       = DATA_W + 1;
    localparam int DIV_W       = BND_W;
    localparam int BRK_W       = BND_W + 1 + CNT_W;
    localparam int CODE_W      = 8;
    localparam int NUM_W       = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [BND_W:0] Q_ONE = (BND_W+1)'(65536);

    localparam logic [CODE_W-1:0] CODE_NODATA = 8'd0;
    localparam logic [CODE_W-1:0] CODE_FIRST  = 8'd1;
    localparam logic [CODE_W-1:0] CODE_TOP    = 8'd255;
    localparam logic [CODE_W-1:0] CODE_SPAN   = 8'd254;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CENTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_SECOND = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     done;
        logic [CODE_W-1:0]        code;
    } pipe_t;

    typedef struct packed {
        logic                    load_brk;
        logic                    load_code;
        logic [CNT_W-1:0]        idx;
        logic signed [BRK_W-1:0] brk;
        logic [CODE_W-1:0]       code;
        logic [CNT_W-1:0]        n;
    } setup_t;

endpackage

`default_nettype wire

// ----- rtl/eic_div.sv -----
// Restoring divider, one quotient bit per cycle, for setup of breaks and codes.
// Depends on eic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eic_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [eic_pkg::DIV_W-1:0]     dividend,
    input  wire logic [eic_pkg::CNT_W-1:0]     divisor,
    output logic      [eic_pkg::DIV_W-1:0]     quot,
    output logic                               rem_nz,
    output logic                               done
);

    localparam int STEP_W = $clog2(eic_pkg::DIV_W + 1);

    logic [eic_pkg::DIV_W-1:0] quot_reg, quot_next;
    logic [eic_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [eic_pkg::CNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [eic_pkg::CNT_W:0]   rem_sh;
    logic [eic_pkg::CNT_W:0]   rem_sub;
    logic                      ge;

    always_comb begin
        rem_sh  = {rem_reg, quot_reg[eic_pkg::DIV_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};

        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = STEP_W'(eic_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[eic_pkg::DIV_W-2:0], ge};
            rem_next  = ge ? rem_sub[eic_pkg::CNT_W-1:0] : rem_sh[eic_pkg::CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign quot   = quot_reg;
    assign rem_nz = rem_reg != '0;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ----- rtl/eic_cell.sv -----
// One class cell: holds the lower and upper break and the code of one class,
// tests each passing sample and hands it on. Depends on eic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eic_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [eic_pkg::IDX_W-1:0]   cidx,
    input  wire eic_pkg::setup_t             setup,
    input  wire logic                        in_valid,
    input  wire eic_pkg::pipe_t              in_data,
    output logic                             in_ready,
    output logic                             out_valid,
    output eic_pkg::pipe_t                   out_data,
    input  wire logic                        out_ready
);

    logic signed [eic_pkg::BRK_W-1:0] lower_reg, lower_next;
    logic signed [eic_pkg::BRK_W-1:0] upper_reg, upper_next;
    logic [eic_pkg::CODE_W-1:0]       code_reg, code_next;
    logic                             valid_reg, valid_next;
    eic_pkg::pipe_t                   data_reg, data_next;
    logic [eic_pkg::CNT_W-1:0]        my_idx;
    logic signed [eic_pkg::BRK_W-1:0] s_ext;
    logic                             active;
    logic                             hit;

    always_comb begin
        my_idx   = eic_pkg::CNT_W'(cidx);
        s_ext    = eic_pkg::BRK_W'(in_data.sample);
        active   = my_idx < setup.n;
        hit      = active && !in_data.done && (s_ext >= lower_reg) && (s_ext < upper_reg);
        in_ready = !valid_reg || out_ready;

        lower_next = lower_reg;
        upper_next = upper_reg;
        code_next  = code_reg;
        if (setup.load_brk && setup.idx == my_idx) begin
            lower_next = setup.brk;
        end
        if (setup.load_brk && setup.idx == my_idx + eic_pkg::CNT_W'(1)) begin
            upper_next = setup.brk;
        end
        if (setup.load_code && setup.idx == my_idx) begin
            code_next = setup.code;
        end

        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            data_next  = in_data;
            if (hit) begin
                data_next.done = 1'b1;
                data_next.code = code_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        code_reg  <= code_next;
        data_reg  <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/equal_interval_pixel_classifier_unit.sv -----
// Top level: configuration registers, setup sequencer, entry stage and the
// row of class cells. Depends on eic_pkg, eic_div and eic_cell.
//
//   channel  | ports                                   | beat
//   ---------+-----------------------------------------+------------------------
//   input    | s_valid s_ready s_sample                | one Q16.16 sample
//   result   | m_valid m_ready m_class_code            | one class code
//   config   | cfg_valid cfg_ready cfg_index cfg_data  | one register write
//
// One sample a cycle while s_ready is high (it drops during setup, while cfg_valid is
// high and when the entry stage is full and stalled). The path has one entry stage
// plus one stage per class cell. After reset and after every register write the
// shared divider computes the class width and each cell's code, with s_ready low.
// A stalled m_ready holds each cell whose successor is full; empty cells fill.
`timescale 1ns / 1ps
`default_nettype none

module equal_interval_pixel_classifier_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [eic_pkg::DATA_W-1:0]      s_sample,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic             [eic_pkg::CODE_W-1:0]      m_class_code,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [eic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [eic_pkg::DATA_W-1:0]      cfg_data
);

    localparam int NC = eic_pkg::MAX_CLASSES;
    localparam int BW = eic_pkg::BND_W;
    localparam int RW = eic_pkg::BRK_W;
    localparam int CW = eic_pkg::CNT_W;

    localparam logic [2:0] ST_BOUNDS = 3'd0;
    localparam logic [2:0] ST_DIFF   = 3'd1;
    localparam logic [2:0] ST_WDIV   = 3'd2;
    localparam logic [2:0] ST_BRK    = 3'd3;
    localparam logic [2:0] ST_CSTART = 3'd4;
    localparam logic [2:0] ST_CWAIT  = 3'd5;
    localparam logic [2:0] ST_RUN    = 3'd6;

    // configuration registers
    logic signed [eic_pkg::DATA_W-1:0] min_reg, min_next;
    logic signed [eic_pkg::DATA_W-1:0] max_reg, max_next;
    logic [eic_pkg::NUM_W-1:0]         num_reg, num_next;
    logic                              zc_reg, zc_next;
    logic signed [eic_pkg::DATA_W-1:0] nd1_reg, nd1_next;
    logic signed [eic_pkg::DATA_W-1:0] nd2_reg, nd2_next;
    logic                              cfg_fire;

    // setup sequencer
    logic [2:0]              state_reg, state_next;
    logic signed [BW-1:0]    lo_reg, lo_next;
    logic signed [BW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]           n_reg, n_next;
    logic signed [RW-1:0]    width_reg, width_next;
    logic signed [RW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic signed [BW-1:0]    mn_ext, mx_ext, neg_mn;
    logic signed [BW:0]      diff;
    logic [BW:0]             diff_mag;
    logic [eic_pkg::DIV_W:0] wmag;
    logic signed [RW-1:0]    wval;
    logic [31:0]             num_wide;

    logic                          div_start;
    logic [eic_pkg::DIV_W-1:0]     div_dividend;
    logic [eic_pkg::DIV_W-1:0]     div_quot;
    logic                          div_rem_nz;
    logic                          div_done;
    eic_pkg::setup_t               setup;

    // entry stage
    logic                  v0_reg, v0_next;
    eic_pkg::pipe_t        p0_reg, p0_next;
    logic                  s_fire;
    logic signed [BW-1:0]  s_ext;
    logic signed [BW:0]    lo_m1;
    logic                  is_nodata, is_top, is_near;

    logic                  valid_d [NC+1];
    eic_pkg::pipe_t        data_d  [NC+1];
    logic                  ready_d [NC+1];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        num_next = num_reg;
        zc_next  = zc_reg;
        nd1_next = nd1_reg;
        nd2_next = nd2_reg;
        if (cfg_fire) begin
            case (cfg_index)
                eic_pkg::REG_MIN_VALUE:     min_next = $signed(cfg_data);
                eic_pkg::REG_MAX_VALUE:     max_next = $signed(cfg_data);
                eic_pkg::REG_NUM_CLASSES:   num_next = cfg_data[eic_pkg::NUM_W-1:0];
                eic_pkg::REG_ZERO_CENTER:   zc_next  = cfg_data[0];
                eic_pkg::REG_NODATA_FIRST:  nd1_next = $signed(cfg_data);
                eic_pkg::REG_NODATA_SECOND: nd2_next = $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        mn_ext   = BW'(min_reg);
        mx_ext   = BW'(max_reg);
        neg_mn   = -mn_ext;
        num_wide = 32'(num_reg);
        diff     = (BW+1)'(hi_reg) - (BW+1)'(lo_reg);
        diff_mag = diff < 0 ? $unsigned(-diff) : $unsigned(diff);
        wmag     = {1'b0, div_quot} + (eic_pkg::DIV_W+1)'(div_rem_nz && neg_reg);
        wval     = $signed(RW'(wmag));

        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        n_next       = n_reg;
        width_next   = width_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        div_start    = 1'b0;
        div_dividend = diff_mag[eic_pkg::DIV_W-1:0];

        setup.load_brk  = 1'b0;
        setup.load_code = 1'b0;
        setup.idx       = cnt_reg;
        setup.brk       = acc_reg;
        setup.code      = div_quot[eic_pkg::CODE_W-1:0] + eic_pkg::CODE_FIRST;
        setup.n         = n_reg;

        case (state_reg)
            ST_BOUNDS: begin
                lo_next = mn_ext;
                hi_next = mx_ext;
                if (zc_reg && min_reg < 0) begin
                    if (neg_mn > mx_ext) begin
                        hi_next = neg_mn;
                    end else begin
                        lo_next = -mx_ext;
                    end
                end
                if (num_reg == '0) begin
                    n_next = CW'(1);
                end else if (num_wide > 32'(NC)) begin
                    n_next = CW'(NC);
                end else begin
                    n_next = CW'(num_reg);
                end
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                neg_next   = diff < 0;
                div_start  = 1'b1;
                state_next = ST_WDIV;
            end
            ST_WDIV: begin
                if (div_done) begin
                    width_next = neg_reg ? -wval : wval;
                    acc_next   = RW'(lo_reg);
                    cnt_next   = '0;
                    state_next = ST_BRK;
                end
            end
            ST_BRK: begin
                setup.load_brk = 1'b1;
                if (cnt_reg == n_reg) begin
                    setup.brk = RW'(hi_reg);
                end else if (zc_reg && !n_reg[0] && cnt_reg == (n_reg >> 1)) begin
                    setup.brk = '0;
                end
                acc_next = acc_reg + width_reg;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NC)) begin
                    cnt_next   = '0;
                    state_next = ST_CSTART;
                end
            end
            ST_CSTART: begin
                div_dividend = eic_pkg::DIV_W'(cnt_reg) * eic_pkg::DIV_W'(eic_pkg::CODE_SPAN);
                div_start    = 1'b1;
                state_next   = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (div_done) begin
                    setup.load_code = 1'b1;
                    cnt_next        = cnt_reg + CW'(1);
                    state_next      = ST_CSTART;
                    if (cnt_reg == CW'(NC - 1)) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
            end
            default: begin
                state_next = ST_BOUNDS;
            end
        endcase

        if (cfg_fire) begin
            state_next = ST_BOUNDS;
        end
    end

    eic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz),
        .done     (div_done)
    );

    assign s_ready = (state_reg == ST_RUN) && !cfg_valid && (!v0_reg || ready_d[0]);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        s_ext     = BW'(s_sample);
        lo_m1     = (BW+1)'(lo_reg) - eic_pkg::Q_ONE;
        is_nodata = (s_sample == nd1_reg) || (s_sample == nd2_reg);
        is_top    = s_ext >= hi_reg;
        is_near   = (s_ext <= lo_reg) && ((BW+1)'(s_ext) > lo_m1);

        v0_next = v0_reg;
        p0_next = p0_reg;
        if (!v0_reg || ready_d[0]) begin
            v0_next        = s_fire;
            p0_next.sample = s_sample;
            p0_next.done   = is_nodata || is_top || is_near;
            if (is_nodata) begin
                p0_next.code = eic_pkg::CODE_NODATA;
            end else if (is_top) begin
                p0_next.code = eic_pkg::CODE_TOP;
            end else begin
                p0_next.code = eic_pkg::CODE_FIRST;
            end
        end
    end

    assign valid_d[0] = v0_reg;
    assign data_d[0]  = p0_reg;

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        eic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cidx      (eic_pkg::IDX_W'(gi)),
            .setup     (setup),
            .in_valid  (valid_d[gi]),
            .in_data   (data_d[gi]),
            .in_ready  (ready_d[gi]),
            .out_valid (valid_d[gi+1]),
            .out_data  (data_d[gi+1]),
            .out_ready (ready_d[gi+1])
        );
    end

    assign ready_d[NC]  = m_ready;
    assign m_valid      = valid_d[NC];
    assign m_class_code = data_d[NC].done ? data_d[NC].code : eic_pkg::CODE_NODATA;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= '0;
            max_reg   <= 32'sh00FF_0000;
            num_reg   <= eic_pkg::NUM_W'(8);
            zc_reg    <= 1'b0;
            nd1_reg   <= 32'sh8000_0000;
            nd2_reg   <= 32'sh8000_0000;
            state_reg <= ST_BOUNDS;
            cnt_reg   <= '0;
            v0_reg    <= 1'b0;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            num_reg   <= num_next;
            zc_reg    <= zc_next;
            nd1_reg   <= nd1_next;
            nd2_reg   <= nd2_next;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v0_reg    <= v0_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        n_reg     <= n_next;
        width_reg <= width_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        p0_reg    <= p0_next;
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for equal_interval_pixel_classifier_unit: random and directed samples
// across many register settings, with a predictor of each class code checked in order.
// Depends on eic_pkg and the RTL of the classifier.
`timescale 1ns / 1ps

module testbench;
    import eic_pkg::*;

    localparam int Q_UNIT          = int'(Q_ONE);
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int CYCLE_LIMIT     = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [CODE_W-1:0]        m_class_code;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;

    logic signed [DATA_W-1:0] min_shadow = '0;
    logic signed [DATA_W-1:0] max_shadow = 32'h00FF0000;
    logic [NUM_W-1:0]         classes_shadow = 5'd8;
    logic                     center_shadow = 1'b0;
    logic signed [DATA_W-1:0] nodata_a_shadow = 32'h80000000;
    logic signed [DATA_W-1:0] nodata_b_shadow = 32'h80000000;

    longint span_lo, span_hi;
    longint brk [0:MAX_CLASSES];
    int     n_eff;

    logic signed [DATA_W-1:0] samples_pending[$];
    logic [CODE_W-1:0]        codes_due[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    equal_interval_pixel_classifier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_class_code(m_class_code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic void refresh_breaks();
        longint mn, mx, w;
        mn = min_shadow;
        mx = max_shadow;
        if (classes_shadow == 0) n_eff = 1;
        else if (classes_shadow > MAX_CLASSES) n_eff = MAX_CLASSES;
        else n_eff = classes_shadow;
        span_lo = mn;
        span_hi = mx;
        if (center_shadow && mn < 0) begin
            if (-mn > mx) begin
                span_hi = -mn;
            end else begin
                span_lo = -mx;
                span_hi = mx;
            end
        end
        w = floor_div(span_hi - span_lo, n_eff);
        for (int i = 0; i <= MAX_CLASSES; i++) begin
            brk[i] = span_lo + i * w;
            if (center_shadow && (n_eff % 2) == 0 && i == n_eff / 2) brk[i] = 0;
            if (i == n_eff) brk[i] = span_hi;
        end
    endfunction

    function automatic logic [CODE_W-1:0] class_code_of(logic signed [DATA_W-1:0] s);
        longint v;
        v = s;
        if (s == nodata_a_shadow || s == nodata_b_shadow) return CODE_NODATA;
        if (v >= span_hi) return CODE_TOP;
        if (v <= span_lo && v > span_lo - Q_UNIT) return CODE_FIRST;
        for (int k = 0; k < n_eff; k++) begin
            if (v >= brk[k] && v < brk[k + 1]) return CODE_W'((k * int'(CODE_SPAN)) / n_eff + 1);
        end
        return CODE_NODATA;
    endfunction

    function automatic logic [DATA_W-1:0] q16(int whole);
        return DATA_W'(whole * Q_UNIT);
    endfunction

    // bias toward bounds, breaks and no-data values of the current setting
    function automatic logic signed [DATA_W-1:0] pick_sample();
        longint v;
        int k;
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? nodata_a_shadow : nodata_b_shadow;
            2: v = span_hi + int'($urandom_range(4)) - 2;
            3: v = span_lo - ($urandom_range(1) ? Q_UNIT : 0) + int'($urandom_range(2)) - 1;
            4: v = span_lo - longint'($urandom_range(2 * Q_UNIT));
            5, 6, 7: begin
                k = $urandom_range(n_eff);
                v = brk[k] + int'($urandom_range(4)) - 2;
            end
            default: begin
                if (span_hi > span_lo)
                    v = span_lo + longint'({$urandom, $urandom} % (span_hi - span_lo));
                else
                    v = span_lo;
            end
        endcase
        if (v != longint'($signed(v[DATA_W-1:0]))) return $urandom;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_q16();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return '0;
            3: return $urandom;
            default: return DATA_W'(int'($urandom_range(600 * Q_UNIT)) - 300 * Q_UNIT);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_VALUE:     min_shadow = val;
            REG_MAX_VALUE:     max_shadow = val;
            REG_NUM_CLASSES:   classes_shadow = val[NUM_W-1:0];
            REG_ZERO_CENTER:   center_shadow = val[0];
            REG_NODATA_FIRST:  nodata_a_shadow = val;
            REG_NODATA_SECOND: nodata_b_shadow = val;
            default: ;
        endcase
        refresh_breaks();
    endtask

    task automatic program_regs(input logic [DATA_W-1:0] mn, input logic [DATA_W-1:0] mx,
                                input logic [NUM_W-1:0] n, input logic zc,
                                input logic [DATA_W-1:0] nd_a, input logic [DATA_W-1:0] nd_b);
        write_reg(REG_MIN_VALUE, mn);
        write_reg(REG_MAX_VALUE, mx);
        write_reg(REG_NUM_CLASSES, DATA_W'(n));
        write_reg(REG_ZERO_CENTER, DATA_W'(zc));
        write_reg(REG_NODATA_FIRST, nd_a);
        write_reg(REG_NODATA_SECOND, nd_b);
    endtask

    task automatic program_random();
        logic [DATA_W-1:0] a, b;
        logic [NUM_W-1:0]  n;
        a = pick_q16();
        b = pick_q16();
        if ($signed(a) > $signed(b) && $urandom_range(3) != 0) {a, b} = {b, a};
        case ($urandom_range(7))
            0: n = '0;
            1: n = NUM_W'($urandom_range(31, MAX_CLASSES + 1));
            default: n = NUM_W'($urandom_range(MAX_CLASSES, 1));
        endcase
        program_regs(a, b, n, 1'($urandom_range(1)),
                     $urandom_range(1) ? pick_q16() : $urandom,
                     $urandom_range(1) ? pick_q16() : $urandom);
    endtask

    task automatic drain();
        while (samples_pending.size() != 0 || s_valid || codes_due.size() != 0) begin
            @(posedge aclk);
            #1;
        end
    endtask

    // driver: advance to the next sample only once the current beat is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= samples_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) codes_due.push_back(class_code_of(s_sample));
    end

    always @(posedge aclk) begin
        logic [CODE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (codes_due.size() == 0) begin
                report_mismatch($sformatf("class code %0d with none due", m_class_code));
            end else begin
                want = codes_due.pop_front();
                if (m_class_code !== want)
                    report_mismatch($sformatf("class code %0d, want %0d", m_class_code, want));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL equal_interval_pixel_classifier_unit");
            $finish;
        end
    end

    initial begin
        refresh_breaks();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        samples_pending.push_back(32'h80000000);
        samples_pending.push_back(32'h7FFFFFFF);
        samples_pending.push_back(0);
        samples_pending.push_back(1);
        samples_pending.push_back(-1);
        samples_pending.push_back(-Q_UNIT + 1);
        samples_pending.push_back(-Q_UNIT);
        samples_pending.push_back(-Q_UNIT - 1);
        samples_pending.push_back(q16(255));
        samples_pending.push_back(q16(255) - 1);
        for (int i = 1; i < n_eff; i++) begin
            samples_pending.push_back(DATA_W'(brk[i] - 1));
            samples_pending.push_back(DATA_W'(brk[i]));
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            case (p)
                0: begin
                    write_reg(REG_SPARE_A, $urandom);
                    write_reg(REG_SPARE_B, $urandom);
                    program_regs(q16(-10), q16(5), 5'd4, 1'b1, q16(3), q16(-3));
                end
                1: program_regs(q16(-3), q16(7), 5'd6, 1'b1, 32'h7FFFFFFF, '0);
                2: program_regs(32'h80000000, 32'h7FFFFFFF, 5'd16, 1'b0, 32'h80000000, 32'h7FFFFFFF);
                3: program_regs(32'h80000000, 32'h7FFFFFFF, 5'd16, 1'b1, '0, '0);
                4: program_regs(q16(5), q16(1), 5'd3, 1'b0, q16(2), q16(7));
                5: program_regs(q16(2), q16(9), 5'd4, 1'b1, q16(4), q16(-8));
                6: program_regs(q16(-1), q16(1), 5'd0, 1'b0, 32'h80000000, 32'h80000000);
                7: program_regs(q16(-100), q16(100), 5'd31, 1'b1, q16(50), q16(-50));
                8: program_regs('0, '0, 5'd1, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF);
                9: program_regs(q16(-40), q16(200), 5'd17, 1'b1, q16(-1), q16(1));
                default: program_random();
            endcase
            // pause mid-phase until every result is back
            for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) samples_pending.push_back(pick_sample());
            drain();
            for (int i = ITEMS_PER_PHASE / 2; i < ITEMS_PER_PHASE; i++)
                samples_pending.push_back(pick_sample());
            drain();
        end

        repeat (MAX_CLASSES + 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS equal_interval_pixel_classifier_unit");
        end else begin
            $display("FAIL equal_interval_pixel_classifier_unit");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/eic_pkg.sv
rtl/eic_div.sv
rtl/eic_cell.sv
rtl/equal_interval_pixel_classifier_unit.sv
tb/testbench.sv
